// ----- rtl/core/irc_fcs_pkg.sv -----
// Package: shared types and constants of the IRC format code stripper.
`timescale 1ns / 1ps

package irc_fcs_pkg;

    localparam int CHAR_BITS   = 16;
    localparam int OUT_BITS    = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CHAR_BITS-1:0] COLOR_CODE = CHAR_BITS'('h03);
    localparam logic [CHAR_BITS-1:0] COMMA_CODE = CHAR_BITS'('h2C);
    localparam logic [CHAR_BITS-1:0] DIGIT_LO   = CHAR_BITS'('h30);
    localparam logic [CHAR_BITS-1:0] DIGIT_HI   = CHAR_BITS'('h39);

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_INTRO = 3'd1,
        PH_FG1   = 3'd2,
        PH_FG2   = 3'd3,
        PH_COMMA = 3'd4,
        PH_BG1   = 3'd5
    } phase_t;

    typedef struct packed {
        logic                 op;
        logic [CHAR_BITS-1:0] character;
    } in_req_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] out_char;
        logic                is_end;
        logic                last_of_run;
    } out_res_t;

    // Work left for the back end by one request
    typedef struct packed {
        logic                emit_comma;
        logic                emit_char;
        logic                emit_end;
        logic [OUT_BITS-1:0] ch;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
        return (c >= DIGIT_LO) && (c <= DIGIT_HI);
    endfunction

    function automatic logic is_dropped(input logic [CHAR_BITS-1:0] c);
        return (c == CHAR_BITS'('h02)) || (c == CHAR_BITS'('h09)) ||
               (c == CHAR_BITS'('h0A)) || (c == CHAR_BITS'('h0E)) ||
               (c == CHAR_BITS'('h0F)) || (c == CHAR_BITS'('h1D)) ||
               (c == CHAR_BITS'('h1E)) || (c == CHAR_BITS'('h1F));
    endfunction

endpackage

// ----- rtl/core/irc_fcs_front.sv -----
// Front end: accepts requests, tracks the colour code phase, queues the work.
`timescale 1ns / 1ps

module irc_fcs_front
    import irc_fcs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_req_t  s_data,
    input  q_stat_t  q_stat,
    output logic     q_push,
    output q_entry_t q_entry
);

    phase_t phase_reg;
    phase_t phase_next;
    logic   accept;
    logic   c_digit;
    logic   c_comma;
    logic   c_color;
    logic   idle_emit;
    phase_t idle_phase;

    assign s_ready   = !q_stat.full;
    assign accept    = s_valid && s_ready;
    assign c_digit   = is_digit(s_data.character);
    assign c_comma   = (s_data.character == COMMA_CODE);
    assign c_color   = (s_data.character == COLOR_CODE);
    assign idle_phase = c_color ? PH_INTRO : PH_IDLE;
    assign idle_emit  = !c_color && !is_dropped(s_data.character);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            if (s_data.op == OP_END) begin
                phase_next = PH_IDLE;
            end else begin
                unique case (phase_reg)
                    PH_INTRO: phase_next = c_digit ? PH_FG1 : idle_phase;
                    PH_FG1: begin
                        if (c_digit)      phase_next = PH_FG2;
                        else if (c_comma) phase_next = PH_COMMA;
                        else              phase_next = idle_phase;
                    end
                    PH_FG2:   phase_next = c_comma ? PH_COMMA : idle_phase;
                    PH_COMMA: phase_next = c_digit ? PH_BG1 : idle_phase;
                    PH_BG1:   phase_next = c_digit ? PH_IDLE : idle_phase;
                    default:  phase_next = idle_phase;
                endcase
            end
        end
    end

    // Work for the back end
    always_comb begin
        q_entry            = '0;
        q_entry.ch         = OUT_BITS'(s_data.character);
        if (s_data.op == OP_END) begin
            q_entry.emit_comma = (phase_reg == PH_COMMA);
            q_entry.emit_end   = 1'b1;
            q_entry.ch         = '0;
        end else begin
            unique case (phase_reg)
                PH_INTRO: q_entry.emit_char = !c_digit && idle_emit;
                PH_FG1:   q_entry.emit_char = !c_digit && !c_comma && idle_emit;
                PH_FG2:   q_entry.emit_char = !c_comma && idle_emit;
                PH_COMMA: begin
                    q_entry.emit_comma = !c_digit;
                    q_entry.emit_char  = !c_digit && idle_emit;
                end
                PH_BG1:   q_entry.emit_char = !c_digit && idle_emit;
                default:  q_entry.emit_char = idle_emit;
            endcase
        end
        q_push = accept &&
                 (q_entry.emit_comma || q_entry.emit_char || q_entry.emit_end);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ----- rtl/core/irc_fcs_queue.sv -----
// Short queue of pending work between the front and back ends.
`timescale 1ns / 1ps

module irc_fcs_queue
    import irc_fcs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_data,
    input  logic     pop,
    output q_entry_t head,
    output q_stat_t  stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_entry_t          mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              do_push;
    logic              do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/irc_fcs_back.sv -----
// Back end: turns queued work into results through the output register.
`timescale 1ns / 1ps

module irc_fcs_back
    import irc_fcs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  q_entry_t head,
    input  q_stat_t  q_stat,
    output logic     pop,
    output logic     m_valid,
    input  logic     m_ready,
    output out_res_t m_data
);

    logic     m_valid_reg;
    logic     m_valid_next;
    out_res_t m_data_reg;
    out_res_t m_data_next;
    logic     comma_done_reg;
    logic     comma_done_next;
    logic     load;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign load    = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        comma_done_next = comma_done_reg;
        pop             = 1'b0;
        if (load && !q_stat.empty) begin
            m_valid_next = 1'b1;
            if (head.emit_comma && !comma_done_reg) begin
                // Held comma goes first; advance only if nothing follows it
                m_data_next.out_char    = OUT_BITS'(COMMA_CODE);
                m_data_next.is_end      = 1'b0;
                m_data_next.last_of_run = !(head.emit_char || head.emit_end);
                pop                     = m_data_next.last_of_run;
                comma_done_next         = !m_data_next.last_of_run;
            end else begin
                m_data_next.out_char    = head.emit_end ? '0 : head.ch;
                m_data_next.is_end      = head.emit_end;
                m_data_next.last_of_run = 1'b1;
                pop                     = 1'b1;
                comma_done_next         = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            comma_done_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            comma_done_reg <= comma_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

// ----- rtl/core/irc_format_code_stripper_top.sv -----
// IRC format code stripper: mIRC colour codes and control characters are removed
// from a stream of UTF-16 code units. The front end takes a request every cycle
// while the work queue (QUEUE_DEPTH entries) has room; the back end delivers one
// result per cycle from its output register while the receiver is ready, so a
// request that yields one result gives one output, one that yields a held comma
// plus a character or end marker gives two, and a dropped request gives none.
// End of text (op 1) flushes a held comma, emits an end marker and returns to idle.
`timescale 1ns / 1ps

module irc_format_code_stripper_top
    import irc_fcs_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_req_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output out_res_t m_data
);

    q_stat_t  q_stat;
    q_entry_t q_entry;
    q_entry_t q_head;
    logic     q_push;
    logic     q_pop;

    irc_fcs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    irc_fcs_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_entry),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    irc_fcs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (q_head),
        .q_stat  (q_stat),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("work pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("work popped from an empty queue");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_end) |-> (m_data.last_of_run && (m_data.out_char == '0)))
        else $error("end marker not last or carries a character");

endmodule
